// ===== hdl/fma_pkg.sv =====
// Shared stage records and a helper function of the binary32 fused multiply-add.
`default_nettype none
package fma_pkg;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               last;
    logic               ps;
    logic               sc;
    logic               cz;
    logic [63:0]        pm;
    logic signed [11:0] pe;
    logic [63:0]        mc;
    logic signed [11:0] xc;
  } fma_prod_t;

  typedef struct packed {
    logic               spec;
    logic [31:0]        spec_val;
    logic               last;
    logic               sign;
    logic [63:0]        x;
    logic signed [11:0] e;
  } fma_sum_t;

  // Count of leading zeros of a 64-bit word; 64 when the word is zero.
  function automatic logic [6:0] lzc64(input logic [63:0] v);
    logic [6:0] n;
    n = 7'd64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        n = 7'(63 - i);
      end
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/fp32_fused_multiply_add.sv =====
// Top level of the pipelined binary32 fused multiply-add.
// The input channel (s_*) carries one operand triple per item: mult_a, mult_b
// and addend as binary32 bit patterns, with s_tlast marking the last element.
// The output channel (m_*) returns mult_a * mult_b + addend rounded once to
// nearest even, with subnormals kept and NaN results as the default quiet NaN;
// m_tlast is the copy of s_tlast for that item.
// The pipeline has six register stages. One item can be accepted in every cycle
// in which the output stage is not stalled.
// All stages advance together; a stage holds its item when the output stage
// is full and m_tready is low, and s_tready then drops in the same cycle, so
// nothing is lost or repeated under backpressure.
// Reset clears the valid bits of all stages; no result is pending afterward.
// The block keeps no state between items.
`default_nettype none
module fp32_fused_multiply_add import fma_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [95:0] s_tdata,  // mult_a, mult_b, addend
  input  wire logic        s_tlast,  // last_in
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,  // sum_out
  output logic             m_tlast   // last_out
);

  logic      en;
  logic      v2, v4;
  fma_prod_t prod;
  fma_sum_t  sum;

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  fma_mul u_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (s_tvalid),
    .mult_a    (s_tdata[31:0]),
    .mult_b    (s_tdata[63:32]),
    .addend    (s_tdata[95:64]),
    .last_in   (s_tlast),
    .out_valid (v2),
    .prod      (prod)
  );

  fma_add u_add (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v2),
    .prod      (prod),
    .out_valid (v4),
    .sum       (sum)
  );

  fma_round u_round (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (v4),
    .sum       (sum),
    .out_valid (m_tvalid),
    .result    (m_tdata),
    .last_out  (m_tlast)
  );

endmodule
`default_nettype wire

// ===== hdl/fma_mul.sv =====
// Operand unpacking, special-case decode, significand product and normalization.
`default_nettype none
module fma_mul import fma_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire logic [31:0] mult_a,
  input  wire logic [31:0] mult_b,
  input  wire logic [31:0] addend,
  input  wire logic        last_in,
  output logic             out_valid,
  output fma_prod_t        prod
);

  logic [7:0]         ea, eb, ec;
  logic [23:0]        ma, mb, mc;
  logic signed [11:0] xa, xb, xc;
  logic               a_nan, b_nan, c_nan, a_inf, b_inf, c_inf, ps, pz;
  logic [6:0]         lzm;
  logic               spec_s1;
  logic [31:0]        val_s1;

  logic               v1;
  logic               spec1, last1, ps1, sc1, cz1;
  logic [31:0]        val1;
  logic [47:0]        pm1;
  logic signed [11:0] pe1, xc1;
  logic [63:0]        mc1;
  logic [6:0]         lzp;
  logic [6:0]         shp;

  always_comb begin
    ea = mult_a[30:23];
    eb = mult_b[30:23];
    ec = addend[30:23];
    ma = {|ea, mult_a[22:0]};
    mb = {|eb, mult_b[22:0]};
    mc = {|ec, addend[22:0]};
    xa = (ea == 8'd0) ? -12'sd149 : $signed({4'b0, ea}) - 12'sd150;
    xb = (eb == 8'd0) ? -12'sd149 : $signed({4'b0, eb}) - 12'sd150;
    xc = (ec == 8'd0) ? -12'sd149 : $signed({4'b0, ec}) - 12'sd150;
    a_nan = (ea == 8'hFF) && (mult_a[22:0] != 23'd0);
    b_nan = (eb == 8'hFF) && (mult_b[22:0] != 23'd0);
    c_nan = (ec == 8'hFF) && (addend[22:0] != 23'd0);
    a_inf = (ea == 8'hFF) && !a_nan;
    b_inf = (eb == 8'hFF) && !b_nan;
    c_inf = (ec == 8'hFF) && !c_nan;
    ps = mult_a[31] ^ mult_b[31];
    pz = (ma == 24'd0) || (mb == 24'd0);
    lzm = lzc64({mc, 40'd0});
    spec_s1 = 1'b1;
    val_s1 = 32'd0;
    if (a_nan || b_nan || c_nan) begin
      val_s1 = QNAN_BITS;
    end else if (a_inf || b_inf) begin
      if ((a_inf && mult_b[30:0] == 31'd0) || (b_inf && mult_a[30:0] == 31'd0)) begin
        val_s1 = QNAN_BITS;
      end else if (c_inf && addend[31] != ps) begin
        val_s1 = QNAN_BITS;
      end else begin
        val_s1 = {ps, INF_BITS[30:0]};
      end
    end else if (c_inf) begin
      val_s1 = addend;
    end else if (pz) begin
      val_s1 = (mc == 24'd0) ? {ps & addend[31], 31'd0} : addend;
    end else begin
      spec_s1 = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      spec1 <= spec_s1;
      val1  <= val_s1;
      last1 <= last_in;
      ps1   <= ps;
      sc1   <= addend[31];
      cz1   <= (mc == 24'd0);
      pm1   <= ma * mb;
      pe1   <= xa + xb;
      mc1   <= {40'd0, mc} << (lzm + 7'd38);
      xc1   <= xc - $signed({5'd0, lzm}) - 12'sd38;
    end
  end

  always_comb begin
    lzp = lzc64({16'd0, pm1});
    shp = lzp - 7'd2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      prod.spec     <= spec1;
      prod.spec_val <= val1;
      prod.last     <= last1;
      prod.ps       <= ps1;
      prod.sc       <= sc1;
      prod.cz       <= cz1;
      prod.pm       <= {16'd0, pm1} << shp[5:0];
      prod.pe       <= pe1 - $signed({5'd0, shp});
      prod.mc       <= mc1;
      prod.xc       <= xc1;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fma_add.sv =====
// Operand ordering, alignment shift with sticky bit, and the wide add or subtract.
`default_nettype none
module fma_add import fma_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      en,
  input  wire logic      in_valid,
  input  wire fma_prod_t prod,
  output logic           out_valid,
  output fma_sum_t       sum
);

  logic               swap;
  logic [63:0]        big_s, small_s;
  logic signed [11:0] d_s;
  logic [63:0]        shifted;
  logic               lost_s;

  logic               v3, spec3, last3, sign3, sub3, lost3;
  logic [31:0]        val3;
  logic [63:0]        big3, small3;
  logic signed [11:0] e3;
  logic [63:0]        x4;

  always_comb begin
    swap = !prod.cz && ((prod.xc > prod.pe) || (prod.xc == prod.pe && prod.mc > prod.pm));
    big_s   = swap ? prod.mc : prod.pm;
    small_s = prod.cz ? 64'd0 : (swap ? prod.pm : prod.mc);
    d_s     = swap ? (prod.xc - prod.pe) : (prod.pe - prod.xc);
    if (d_s >= 12'sd64) begin
      shifted = 64'd0;
      lost_s  = (small_s != 64'd0);
    end else begin
      shifted = small_s >> d_s[5:0];
      lost_s  = (small_s & ((64'd1 << d_s[5:0]) - 64'd1)) != 64'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= in_valid;
    end
    if (en) begin
      spec3  <= prod.spec;
      val3   <= prod.spec_val;
      last3  <= prod.last;
      sign3  <= swap ? prod.sc : prod.ps;
      sub3   <= (prod.sc != prod.ps) && !prod.cz;
      big3   <= big_s;
      small3 <= shifted;
      lost3  <= lost_s;
      e3     <= swap ? prod.xc : prod.pe;
    end
  end

  always_comb begin
    if (sub3) begin
      x4 = big3 - small3 - {63'd0, lost3};
    end else begin
      x4 = big3 + small3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v3;
    end
    if (en) begin
      sum.last <= last3;
      sum.sign <= sign3;
      sum.x    <= x4 | {63'd0, lost3};
      sum.e    <= e3;
      if (spec3) begin
        sum.spec     <= 1'b1;
        sum.spec_val <= val3;
      end else begin
        sum.spec     <= sub3 && (x4 == 64'd0) && !lost3;
        sum.spec_val <= 32'd0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/fma_round.sv =====
// Normalization, round to nearest even, subnormal and overflow handling, packing.
`default_nettype none
module fma_round import fma_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        en,
  input  wire logic        in_valid,
  input  wire fma_sum_t    sum,
  output logic             out_valid,
  output logic [31:0]      result,
  output logic             last_out
);

  logic [6:0]         lz;
  logic signed [11:0] bexp;
  logic signed [11:0] sh_s;

  logic               v5, spec5, last5, sign5, zero5;
  logic [31:0]        val5;
  logic [63:0]        sn5;
  logic [6:0]         sh5;
  logic [11:0]        base5;

  logic [6:0]         shm1;
  logic [23:0]        mant;
  logic               rbit, stk, up;
  logic [35:0]        bits;
  logic [31:0]        packed_val;

  always_comb begin
    lz   = lzc64(sum.x);
    bexp = sum.e - $signed({5'd0, lz}) + 12'sd190;
    sh_s = (bexp >= 12'sd1) ? 12'sd40 : (12'sd41 - bexp);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= in_valid;
    end
    if (en) begin
      spec5 <= sum.spec;
      val5  <= sum.spec_val;
      last5 <= sum.last;
      sign5 <= sum.sign;
      sn5   <= sum.x << lz[5:0];
      zero5 <= sh_s > 12'sd64;
      sh5   <= (sh_s > 12'sd64) ? 7'd64 : sh_s[6:0];
      base5 <= (bexp >= 12'sd1) ? 12'(bexp - 12'sd1) : 12'd0;
    end
  end

  always_comb begin
    shm1 = sh5 - 7'd1;
    mant = (sh5 == 7'd64) ? 24'd0 : 24'(sn5 >> sh5[5:0]);
    rbit = sn5[shm1[5:0]];
    stk  = (sn5 & ((64'd1 << shm1[5:0]) - 64'd1)) != 64'd0;
    up   = rbit && (stk || mant[0]);
    bits = {1'b0, base5, 23'd0} + {12'd0, mant} + {35'd0, up};
    if (bits >= {4'd0, INF_BITS}) begin
      bits = {4'd0, INF_BITS};
    end
    if (spec5) begin
      packed_val = val5;
    end else if (zero5) begin
      packed_val = {sign5, 31'd0};
    end else begin
      packed_val = {sign5, bits[30:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
    if (en) begin
      result   <= packed_val;
      last_out <= last5;
    end
  end

endmodule
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for the binary32 fused multiply-add stream.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [95:0] s_tdata = '0;  // mult_a, mult_b, addend
  logic        s_tlast = 1'b0;  // last_in
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;  // sum_out
  logic        m_tlast;  // last_out

  typedef struct packed {
    logic [31:0] sum;
    logic        last;
  } fma_result_t;

  fma_result_t sums_pending[$];
  int          fail_count = 0;
  int          idle_cycles = 0;
  bit          hold_off = 1'b0;
  bit          no_stalls = 1'b0;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;
  localparam logic [31:0] POS_INF = 32'h7F80_0000;

  fp32_fused_multiply_add dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int count_lead(input logic [63:0] v);
    int n;
    n = 64;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        n = 63 - i;
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] round_to_single(input logic sign, input logic [63:0] s,
                                                  input int e);
    int          lz;
    int          bexp;
    int          sh;
    int          base;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    logic [63:0] bits;
    lz = count_lead(s);
    s = s << lz;
    e = e - lz;
    bexp = e + 63 + 127;
    if (bexp >= 1) begin
      sh = 40;
      base = bexp - 1;
    end else begin
      sh = 41 - bexp;
      base = 0;
    end
    if (sh > 64) begin
      return {sign, 31'd0};
    end
    if (sh == 64) begin
      mant = 0;
      rem = s;
      half = 64'h8000_0000_0000_0000;
    end else begin
      mant = s >> sh;
      rem = s & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
    end
    if (rem > half || (rem == half && mant[0])) begin
      mant = mant + 1;
    end
    bits = (64'(base) << 23) + mant;
    if (bits >= 64'(POS_INF)) begin
      bits = 64'(POS_INF);
    end
    return {sign, bits[30:0]};
  endfunction

  function automatic logic [31:0] fused_sum(input logic [31:0] a, input logic [31:0] b,
                                            input logic [31:0] c);
    logic [63:0] ma, mb, mc, pm, big, little, x;
    int          xa, xb, xc, pe, ebig, d;
    logic        ps, sbig, slittle, lost;
    logic        a_nan, b_nan, c_nan, a_inf, b_inf, c_inf;
    ma = (a[30:23] == 0) ? 64'(a[22:0]) : 64'({1'b1, a[22:0]});
    mb = (b[30:23] == 0) ? 64'(b[22:0]) : 64'({1'b1, b[22:0]});
    mc = (c[30:23] == 0) ? 64'(c[22:0]) : 64'({1'b1, c[22:0]});
    xa = (a[30:23] == 0) ? -149 : int'(a[30:23]) - 150;
    xb = (b[30:23] == 0) ? -149 : int'(b[30:23]) - 150;
    xc = (c[30:23] == 0) ? -149 : int'(c[30:23]) - 150;
    a_nan = &a[30:23] && |a[22:0];
    b_nan = &b[30:23] && |b[22:0];
    c_nan = &c[30:23] && |c[22:0];
    a_inf = &a[30:23] && !a_nan;
    b_inf = &b[30:23] && !b_nan;
    c_inf = &c[30:23] && !c_nan;
    ps = a[31] ^ b[31];
    if (a_nan || b_nan || c_nan) begin
      return DEFAULT_NAN;
    end
    if (a_inf || b_inf) begin
      if ((a_inf && b[30:0] == 0) || (b_inf && a[30:0] == 0)) begin
        return DEFAULT_NAN;
      end
      if (c_inf && c[31] != ps) begin
        return DEFAULT_NAN;
      end
      return {ps, POS_INF[30:0]};
    end
    if (c_inf) begin
      return c;
    end
    pm = ma * mb;
    pe = xa + xb;
    if (pm == 0) begin
      if (mc == 0) begin
        return {ps & c[31], 31'd0};
      end
      return c;
    end
    if (mc == 0) begin
      return round_to_single(ps, pm, pe);
    end
    d = count_lead(pm) - 2;
    pm = pm << d;
    pe = pe - d;
    d = count_lead(mc) - 2;
    mc = mc << d;
    xc = xc - d;
    if (pe > xc || (pe == xc && pm >= mc)) begin
      big = pm; ebig = pe; sbig = ps; little = mc; slittle = c[31]; d = pe - xc;
    end else begin
      big = mc; ebig = xc; sbig = c[31]; little = pm; slittle = ps; d = xc - pe;
    end
    if (d >= 64) begin
      lost = 1'b1;
      little = 0;
    end else begin
      lost = d > 0 && (little & ((64'd1 << d) - 64'd1)) != 0;
      little = little >> d;
    end
    if (sbig == slittle) begin
      x = big + little;
    end else begin
      x = big - little;
      if (lost) begin
        x = x - 1;
      end
      if (x == 0 && !lost) begin
        return 32'd0;
      end
    end
    if (lost) begin
      x[0] = 1'b1;
    end
    return round_to_single(sbig, x, ebig);
  endfunction

  task automatic send_triple(input logic [31:0] a, input logic [31:0] b, input logic [31:0] c,
                             input logic last);
    fma_result_t r;
    s_tvalid <= 1'b1;
    s_tdata <= {c, b, a};
    s_tlast <= last;
    r.sum = fused_sum(a, b, c);
    r.last = last;
    do @(posedge clk); while (!s_tready);
    sums_pending.push_back(r);
  endtask

  task automatic pause_sender();
    int gap;
    gap = no_stalls ? 0 : (($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Operand drawn from a mix of special encodings and random patterns.
  function automatic logic [31:0] pick_operand();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 11))
      0: v[30:23] = 8'd0;
      1: v[30:23] = 8'hFF;
      2: v[30:0] = 31'd0;
      3: v[30:23] = 8'($urandom_range(1, 30));
      4: v[30:23] = 8'($urandom_range(225, 254));
      5: v[30:23] = 8'($urandom_range(110, 145));
      default: v[30:23] = 8'($urandom_range(90, 165));
    endcase
    return v;
  endfunction

  task automatic test_special_cases();
    send_triple(32'h3F80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
    send_triple(32'h7FC0_1234, 32'h3F80_0000, 32'h0000_0000, 1'b1);
    send_triple(32'h3F80_0000, 32'hFF80_0001, 32'h0000_0000, 1'b0);
    send_triple(32'h3F80_0000, 32'h3F80_0000, 32'h7FFF_FFFF, 1'b0);
    send_triple(32'h7F80_0000, 32'h0000_0000, 32'h3F80_0000, 1'b0);
    send_triple(32'h8000_0000, 32'hFF80_0000, 32'h3F80_0000, 1'b0);
    send_triple(32'h7F80_0000, 32'h3F80_0000, 32'hFF80_0000, 1'b0);
    send_triple(32'hFF80_0000, 32'h3F80_0000, 32'h7F80_0000, 1'b0);
    send_triple(32'h7F80_0000, 32'hBF80_0000, 32'h4000_0000, 1'b1);
    send_triple(32'h4000_0000, 32'h4000_0000, 32'hFF80_0000, 1'b0);
    send_triple(32'h4000_0000, 32'h3F80_0000, 32'hC000_0000, 1'b0);
    send_triple(32'h8000_0000, 32'h3F80_0000, 32'h8000_0000, 1'b0);
    send_triple(32'h0000_0000, 32'h3F80_0000, 32'h8000_0000, 1'b0);
    send_triple(32'h0000_0000, 32'h0000_0000, 32'h4040_0000, 1'b0);
    send_triple(32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h0000_0000, 1'b0);
    send_triple(32'hFF7F_FFFF, 32'h4000_0000, 32'h7F7F_FFFF, 1'b0);
    send_triple(32'h0000_0001, 32'h3F00_0000, 32'h0000_0000, 1'b0);
    send_triple(32'h0000_0003, 32'h3F00_0000, 32'h0000_0000, 1'b0);
    send_triple(32'h0080_0000, 32'h3F00_0000, 32'h8000_0001, 1'b0);
    send_triple(32'h007F_FFFF, 32'h007F_FFFF, 32'h0000_0001, 1'b0);
    send_triple(32'h3F80_0001, 32'h3F80_0001, 32'hBF80_0002, 1'b0);
    send_triple(32'h4B80_0000, 32'h3F80_0000, 32'h3F80_0000, 1'b0);
    send_triple(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
  endtask

  task automatic test_random_stream(input int count);
    for (int i = 0; i < count; i++) begin
      if (i % 200 == 0) begin
        no_stalls = (i % 400 == 0);
      end
      pause_sender();
      send_triple(pick_operand(), pick_operand(), pick_operand(), 1'($urandom_range(0, 1)));
    end
    no_stalls = 1'b0;
    s_tvalid <= 1'b0;
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    for (int i = 0; i < 20; i++) begin
      send_triple($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_off || no_stalls) begin
      m_tready <= !hold_off;
    end else begin
      m_tready <= ($urandom_range(0, 6) > 1);
    end
  end

  initial begin
    int cnt;
    wait (hold_off);
    cnt = 0;
    while (cnt < 60) begin
      @(posedge clk);
      cnt++;
    end
    hold_off = 1'b0;
  end

  always @(posedge clk) begin
    fma_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (sums_pending.size() == 0) begin
        $error("unexpected item: sum_out %h last_out %b", m_tdata, m_tlast);
        fail_count++;
      end else begin
        want = sums_pending.pop_front();
        if (m_tdata !== want.sum) begin
          $error("sum_out expected %h actual %h", want.sum, m_tdata);
          fail_count++;
        end
        if (m_tlast !== want.last) begin
          $error("last_out expected %b actual %b", want.last, m_tlast);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("fp32_fused_multiply_add: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_special_cases();
    test_backpressure();
    test_random_stream(1500);
    wait (sums_pending.size() == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("fp32_fused_multiply_add: match");
    end else begin
      $display("fp32_fused_multiply_add: mismatch");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== sim.f =====
hdl/fma_pkg.sv
hdl/fma_mul.sv
hdl/fma_add.sv
hdl/fma_round.sv
hdl/fp32_fused_multiply_add.sv
tb/tb_top.sv
